// ===== design/cll_pkg.sv =====
`timescale 1ns / 1ps

package cll_pkg;

    typedef enum logic [2:0] {
        CMD_INSERT      = 3'd0,
        CMD_ERASE       = 3'd1,
        CMD_ERASE_RANGE = 3'd2,
        CMD_RETRIEVE    = 3'd3,
        CMD_NEXT        = 3'd4,
        CMD_PREVIOUS    = 3'd5,
        CMD_CLEAR       = 3'd6,
        CMD_NOP         = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    // datapath micro-operations, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_SWEEP,
        OP_ACCEPT,
        OP_BAD,
        OP_NOFREE,
        OP_INS_RD,
        OP_INS_A,
        OP_INS_B,
        OP_ERA_RD,
        OP_ERA_A,
        OP_ERA_B,
        OP_RET_RD,
        OP_RET,
        OP_NEXT,
        OP_PRV_START,
        OP_PRV_HIT,
        OP_PRV_ADV,
        OP_RNG_Q,
        OP_RNG_LQ,
        OP_RNG_RD,
        OP_RNG_ADV,
        OP_CUT,
        OP_FRE_RD,
        OP_FRE_WR,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_cmd cmd;
        logic sweep_last;
        logic p_ok;
        logic q_ok;
        logic rd_null;
        logic rd_hit;
        logic free_empty;
        logic p_eq_q;
        logic walk_hit;
        logic walk_end;
        logic fre_stop;
        logic cnt_full;
        logic out_free;
    } t_flags;

    localparam int PosW  = 7;
    localparam int ValW  = 32;
    localparam int DataW = 48;

endpackage

// ===== design/cll_ctrl.sv =====
`timescale 1ns / 1ps

module cll_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  cll_pkg::t_flags i_flags,
    output logic            o_in_ready,
    output cll_pkg::t_op    o_op
);

    typedef enum logic [15:0] {
        S_SWEEP   = 16'h0001,
        S_IDLE    = 16'h0002,
        S_FETCH   = 16'h0004,
        S_INS_A   = 16'h0008,
        S_INS_B   = 16'h0010,
        S_ERA_A   = 16'h0020,
        S_ERA_B   = 16'h0040,
        S_RET     = 16'h0080,
        S_PRV     = 16'h0100,
        S_RNG_Q   = 16'h0200,
        S_RNG_CHK = 16'h0400,
        S_RNG_ADV = 16'h0800,
        S_FRE_CHK = 16'h1000,
        S_FRE_WR  = 16'h2000,
        S_FIN     = 16'h4000,
        S_SPARE   = 16'h8000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = cll_pkg::OP_NONE;
        case (r_state)
            S_SWEEP: begin
                o_op = cll_pkg::OP_SWEEP;
                if (i_flags.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = cll_pkg::OP_ACCEPT;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_FIN;
                case (i_flags.cmd)
                    cll_pkg::CMD_INSERT: begin
                        if (!i_flags.p_ok) o_op = cll_pkg::OP_BAD;
                        else if (i_flags.free_empty) o_op = cll_pkg::OP_NOFREE;
                        else begin
                            o_op    = cll_pkg::OP_INS_RD;
                            n_state = S_INS_A;
                        end
                    end
                    cll_pkg::CMD_ERASE: begin
                        if (!i_flags.p_ok || i_flags.rd_null) o_op = cll_pkg::OP_BAD;
                        else begin
                            o_op    = cll_pkg::OP_ERA_RD;
                            n_state = S_ERA_A;
                        end
                    end
                    cll_pkg::CMD_RETRIEVE: begin
                        if (!i_flags.p_ok || i_flags.rd_null) o_op = cll_pkg::OP_BAD;
                        else begin
                            o_op    = cll_pkg::OP_RET_RD;
                            n_state = S_RET;
                        end
                    end
                    cll_pkg::CMD_NEXT: begin
                        o_op = i_flags.p_ok ? cll_pkg::OP_NEXT : cll_pkg::OP_BAD;
                    end
                    cll_pkg::CMD_PREVIOUS: begin
                        if (!i_flags.p_ok) o_op = cll_pkg::OP_BAD;
                        else begin
                            o_op    = cll_pkg::OP_PRV_START;
                            n_state = S_PRV;
                        end
                    end
                    cll_pkg::CMD_ERASE_RANGE: begin
                        if (!i_flags.p_ok) o_op = cll_pkg::OP_BAD;
                        else begin
                            o_op    = cll_pkg::OP_RNG_Q;
                            n_state = S_RNG_Q;
                        end
                    end
                    cll_pkg::CMD_CLEAR: begin
                        o_op    = cll_pkg::OP_RNG_Q;
                        n_state = S_RNG_Q;
                    end
                    default: o_op = cll_pkg::OP_NONE;
                endcase
            end
            S_INS_A: begin
                o_op    = cll_pkg::OP_INS_A;
                n_state = S_INS_B;
            end
            S_INS_B: begin
                o_op    = cll_pkg::OP_INS_B;
                n_state = S_FIN;
            end
            S_ERA_A: begin
                o_op    = cll_pkg::OP_ERA_A;
                n_state = S_ERA_B;
            end
            S_ERA_B: begin
                o_op    = cll_pkg::OP_ERA_B;
                n_state = S_FIN;
            end
            S_RET: begin
                o_op    = cll_pkg::OP_RET;
                n_state = S_FIN;
            end
            S_PRV: begin
                if (i_flags.cnt_full || i_flags.rd_null) begin
                    o_op    = cll_pkg::OP_BAD;
                    n_state = S_FIN;
                end else if (i_flags.rd_hit) begin
                    o_op    = cll_pkg::OP_PRV_HIT;
                    n_state = S_FIN;
                end else begin
                    o_op = cll_pkg::OP_PRV_ADV;
                end
            end
            S_RNG_Q: begin
                if (i_flags.cmd != cll_pkg::CMD_CLEAR && !i_flags.q_ok) begin
                    o_op    = cll_pkg::OP_BAD;
                    n_state = S_FIN;
                end else if (i_flags.p_eq_q) begin
                    n_state = S_FIN;
                end else begin
                    o_op    = cll_pkg::OP_RNG_LQ;
                    n_state = S_RNG_CHK;
                end
            end
            S_RNG_CHK: begin
                if (i_flags.cnt_full || i_flags.walk_end) begin
                    // end not reached: clear still reports ok
                    if (i_flags.cmd != cll_pkg::CMD_CLEAR) o_op = cll_pkg::OP_BAD;
                    n_state = S_FIN;
                end else if (i_flags.walk_hit) begin
                    o_op    = cll_pkg::OP_CUT;
                    n_state = S_FRE_CHK;
                end else begin
                    o_op    = cll_pkg::OP_RNG_RD;
                    n_state = S_RNG_ADV;
                end
            end
            S_RNG_ADV: begin
                o_op    = cll_pkg::OP_RNG_ADV;
                n_state = S_RNG_CHK;
            end
            S_FRE_CHK: begin
                if (i_flags.cnt_full || i_flags.fre_stop) begin
                    n_state = S_FIN;
                end else begin
                    o_op    = cll_pkg::OP_FRE_RD;
                    n_state = S_FRE_WR;
                end
            end
            S_FRE_WR: begin
                o_op    = cll_pkg::OP_FRE_WR;
                n_state = S_FRE_CHK;
            end
            S_FIN: begin
                if (i_flags.out_free) begin
                    o_op    = cll_pkg::OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== design/cll_dp.sv =====
`timescale 1ns / 1ps

module cll_dp #(
    parameter int CELL_COUNT = 128
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cll_pkg::t_op              i_op,
    input  logic [cll_pkg::DataW-1:0] i_in_data,
    input  logic [2:0]                i_in_cmd,
    input  logic                      i_out_ready,
    output cll_pkg::t_flags           o_flags,
    output logic                      o_out_valid,
    output logic [cll_pkg::DataW-1:0] o_out_data,
    output logic [1:0]                o_out_status
);

    localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] NL = LW'(CELL_COUNT);
    localparam int PW = cll_pkg::PosW;
    localparam int VW = cll_pkg::ValW;

    // link memory entry: {in_use, link}
    logic [LW:0]    r_lmem [CELL_COUNT];
    logic [VW-1:0]  r_emem [CELL_COUNT];
    logic [LW:0]    r_lrd;
    logic [VW-1:0]  r_erd;

    logic           lm_we;
    logic [AW-1:0]  lm_wa, lm_ra, em_ra;
    logic [LW:0]    lm_wd;
    logic           em_we;

    cll_pkg::t_cmd  r_cmd;
    logic [PW-1:0]  r_rpos;
    logic [AW-1:0]  r_pa, r_qa, r_c;
    logic           r_p_in, r_q_in;
    logic [VW-1:0]  r_val, r_rd;
    logic [LW-1:0]  r_lp, r_lq, r_cur, r_cnt, r_free_top;
    logic [AW-1:0]  r_tail;
    cll_pkg::t_status r_status;
    logic           r_isnull;
    logic           r_out_valid;
    logic [cll_pkg::DataW-1:0] r_out_data;
    logic [1:0]     r_out_status;

    logic [PW-1:0]  in_pos, in_end;
    logic [VW-1:0]  in_val;
    logic           in_clear;
    logic [LW-1:0]  rd_link;
    logic           rd_use;

    assign in_pos   = i_in_data[PW-1:0];
    assign in_end   = i_in_data[2*PW-1:PW];
    assign in_val   = i_in_data[2*PW+VW-1:2*PW];
    assign in_clear = (i_in_cmd == cll_pkg::CMD_CLEAR);
    assign rd_link  = r_lrd[LW-1:0];
    assign rd_use   = r_lrd[LW];

    always_comb begin
        o_flags.cmd        = r_cmd;
        o_flags.sweep_last = (r_cnt == LW'(CELL_COUNT - 1));
        o_flags.p_ok       = r_p_in && rd_use;
        o_flags.q_ok       = r_q_in && rd_use;
        o_flags.rd_null    = (rd_link >= NL);
        o_flags.rd_hit     = (rd_link == {1'b0, r_pa});
        o_flags.free_empty = (r_free_top >= NL);
        o_flags.p_eq_q     = (r_pa == r_qa);
        o_flags.walk_hit   = (r_cur == {1'b0, r_qa});
        o_flags.walk_end   = (r_cur >= NL);
        o_flags.fre_stop   = (r_cur == r_lq) || (r_cur >= NL);
        o_flags.cnt_full   = (r_cnt == NL);
        o_flags.out_free   = !r_out_valid || i_out_ready;
    end

    // memory port selection
    always_comb begin
        lm_we = 1'b0;
        lm_wa = r_cur[AW-1:0];
        lm_wd = '0;
        em_we = 1'b0;
        lm_ra = r_cur[AW-1:0];
        em_ra = rd_link[AW-1:0];
        case (i_op)
            cll_pkg::OP_SWEEP: begin
                lm_we = 1'b1;
                lm_wa = r_cnt[AW-1:0];
                lm_wd = (r_cnt == '0) ? {1'b1, NL} : {1'b0, r_cnt + LW'(1)};
            end
            cll_pkg::OP_ACCEPT: lm_ra = in_clear ? '0 : AW'(in_pos);
            cll_pkg::OP_INS_RD: lm_ra = r_free_top[AW-1:0];
            cll_pkg::OP_INS_A: begin
                lm_we = 1'b1;
                lm_wa = r_free_top[AW-1:0];
                lm_wd = {1'b1, r_lp};
                em_we = 1'b1;
            end
            cll_pkg::OP_INS_B: begin
                lm_we = 1'b1;
                lm_wa = r_pa;
                lm_wd = {1'b1, 1'b0, r_c};
            end
            cll_pkg::OP_ERA_RD: lm_ra = rd_link[AW-1:0];
            cll_pkg::OP_ERA_A: begin
                lm_we = 1'b1;
                lm_wa = r_pa;
                lm_wd = {1'b1, rd_link};
            end
            cll_pkg::OP_ERA_B: begin
                lm_we = 1'b1;
                lm_wa = r_lp[AW-1:0];
                lm_wd = {1'b0, r_free_top};
            end
            cll_pkg::OP_PRV_START: lm_ra = '0;
            cll_pkg::OP_PRV_ADV:   lm_ra = rd_link[AW-1:0];
            cll_pkg::OP_RNG_Q:     lm_ra = r_qa;
            cll_pkg::OP_CUT: begin
                lm_we = 1'b1;
                lm_wa = r_pa;
                lm_wd = {1'b1, r_lq};
            end
            cll_pkg::OP_FRE_WR: begin
                lm_we = 1'b1;
                lm_wa = r_cur[AW-1:0];
                lm_wd = {1'b0, r_free_top};
            end
            default: lm_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lm_we) r_lmem[lm_wa] <= lm_wd;
        r_lrd <= r_lmem[lm_ra];
        if (em_we) r_emem[r_free_top[AW-1:0]] <= r_val;
        r_erd <= r_emem[em_ra];
    end

    // list control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_free_top  <= LW'(1);
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && i_op != cll_pkg::OP_EMIT)
                r_out_valid <= 1'b0;
            case (i_op)
                cll_pkg::OP_SWEEP:  r_cnt <= r_cnt + LW'(1);
                cll_pkg::OP_INS_A:  r_free_top <= rd_link;
                cll_pkg::OP_INS_B:  if (r_lp == NL) r_tail <= r_c;
                cll_pkg::OP_ERA_A:  if (r_lp == {1'b0, r_tail}) r_tail <= r_pa;
                cll_pkg::OP_ERA_B:  r_free_top <= r_lp;
                cll_pkg::OP_PRV_START, cll_pkg::OP_RNG_LQ: r_cnt <= '0;
                cll_pkg::OP_PRV_ADV, cll_pkg::OP_RNG_RD, cll_pkg::OP_FRE_RD:
                    r_cnt <= r_cnt + LW'(1);
                cll_pkg::OP_CUT: begin
                    r_cnt <= '0;
                    if (r_lq == NL) r_tail <= r_pa;
                end
                cll_pkg::OP_FRE_WR: r_free_top <= r_cur;
                cll_pkg::OP_EMIT:   r_out_valid <= 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // per-item payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            cll_pkg::OP_ACCEPT: begin
                r_cmd    <= cll_pkg::t_cmd'(i_in_cmd);
                r_val    <= in_val;
                r_pa     <= in_clear ? '0 : AW'(in_pos);
                r_qa     <= in_clear ? r_tail : AW'(in_end);
                r_p_in   <= in_clear || (32'(in_pos) < CELL_COUNT);
                r_q_in   <= in_clear || (32'(in_end) < CELL_COUNT);
                r_rpos   <= in_clear ? '0 : in_pos;
                r_status <= cll_pkg::ST_OK;
                r_isnull <= 1'b0;
                r_rd     <= '0;
            end
            cll_pkg::OP_BAD:    r_status <= cll_pkg::ST_BADPOS;
            cll_pkg::OP_NOFREE: r_status <= cll_pkg::ST_NOFREE;
            cll_pkg::OP_INS_RD: begin
                r_lp <= rd_link;
                r_c  <= r_free_top[AW-1:0];
            end
            cll_pkg::OP_ERA_RD, cll_pkg::OP_RNG_Q: r_lp <= rd_link;
            cll_pkg::OP_RET: r_rd <= r_erd;
            cll_pkg::OP_NEXT: begin
                r_isnull <= (rd_link >= NL);
                r_rpos   <= (rd_link >= NL) ? '0 : PW'(rd_link);
            end
            cll_pkg::OP_PRV_START: r_cur <= '0;
            cll_pkg::OP_PRV_HIT:   r_rpos <= PW'(r_cur);
            cll_pkg::OP_PRV_ADV, cll_pkg::OP_RNG_ADV: r_cur <= rd_link;
            cll_pkg::OP_RNG_LQ: begin
                r_lq  <= rd_link;
                r_cur <= r_lp;
            end
            cll_pkg::OP_CUT:    r_cur <= r_lp;
            cll_pkg::OP_FRE_WR: r_cur <= rd_link;
            cll_pkg::OP_EMIT: begin
                r_out_status <= r_status;
                r_out_data   <= {1'b0, PW'(r_tail), r_rd, r_isnull, r_rpos};
            end
            default: r_cur <= r_cur;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_out_status = r_out_status;

endmodule

// ===== design/cursor_linked_list_engine.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | tdata (low bit up)                              | tuser
// s_axis   | in        | position[6:0], end_position[13:7], value[45:14] | cmd[2:0]
// m_axis   | out       | result_position[6:0], result_is_null[7],        | status[1:0]
//          |           | read_value[39:8], tail_position[46:40]          |
// One command at a time on a link memory with one write port and a registered
// read port: previous walks the links from the head until it finds the cell
// before the position; erase range and clear walk the links to find the end,
// then free each removed cell in turn.
// After reset the link memory is swept, one cell per cycle, over all CELL_COUNT
// cells; tready stays low meanwhile. A result waiting on m_axis holds up
// only the completion of the next command, not its acceptance.

module cursor_linked_list_engine #(
    parameter int CELL_COUNT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // position, end_position, value, pad
    input  logic [2:0]  i_s_axis_tuser,  // cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // result_position, result_is_null,
                                         // read_value, tail_position, pad
    output logic [1:0]  o_m_axis_tuser   // status
);

    cll_pkg::t_flags flags;
    cll_pkg::t_op    op;

    cll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_flags    (flags),
        .o_in_ready (o_s_axis_tready),
        .o_op       (op)
    );

    cll_dp #(
        .CELL_COUNT (CELL_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_in_data    (i_s_axis_tdata),
        .i_in_cmd     (i_s_axis_tuser),
        .i_out_ready  (i_m_axis_tready),
        .o_flags      (flags),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_data   (o_m_axis_tdata),
        .o_out_status (o_m_axis_tuser)
    );

endmodule

// ===== design/cll_checker.sv =====
`timescale 1ns / 1ps

module cll_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // stalled result transfer stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // one command in flight: no accept right after an accept
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted back to back");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser <= cll_pkg::ST_BADPOS)
        else $error("undefined status code");

    // failed commands read nothing
    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != cll_pkg::ST_OK |->
            o_m_axis_tdata[39:8] == 32'd0)
        else $error("read data on failed command");

    a_null_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[7] |->
            o_m_axis_tdata[6:0] == 7'd0 && o_m_axis_tuser == cll_pkg::ST_OK)
        else $error("null result with nonzero position");

endmodule

bind cursor_linked_list_engine cll_checker u_cll_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
